// ===== rtl/kvx_pkg.sv =====
// kvx_pkg: shared types and constants of the json key/value extractor
`default_nettype none

package kvx_pkg;

  localparam int KEY_CHARS = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd2;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_COMMA    = 8'h2c;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3a;
  localparam logic [7:0] CH_RBRACKET = 8'h5d;
  localparam logic [7:0] CH_RBRACE   = 8'h7d;

  localparam logic [62:0] NUM_MAX = {63{1'b1}};
  localparam logic [15:0] LEN_MAX = 16'hffff;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_COLON,
    PH_SPACE,
    PH_OPENED,
    PH_VALUE,
    PH_DONE
  } kvx_phase_t;

  typedef enum logic [1:0] {
    DS_START,
    DS_DIGITS,
    DS_STOP
  } kvx_digit_t;

  typedef struct packed {
    logic [7:0] doc_byte;
    logic       doc_end;
  } kvx_in_t;

  typedef struct packed {
    logic        is_summary;
    logic [7:0]  value_char;
    logic        found;
    logic        unterminated;
    logic [15:0] value_length;
    logic        number_valid;
    logic [62:0] number;
  } kvx_out_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } kvx_win_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/kvx_key_match.sv =====
// kvx_key_match: byte window and quoted key compare
`default_nettype none

module kvx_key_match
  import kvx_pkg::*;
#(
  parameter int KEY_MAX = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire kvx_win_ctl_t             ctl,
  input  wire logic [7:0]               din,
  input  wire logic [4:0]               key_len,
  input  wire logic [8*KEY_CHARS-1:0]   key_chars,
  output logic                          hit
);

  localparam int WIN = KEY_MAX + 2;
  localparam int LW  = $clog2(KEY_MAX + 1);

  logic [7:0]    win_r [WIN];
  logic [7:0]    win_nxt [WIN];
  logic [LW-1:0] len_cap;
  logic [LW-1:0] eff_len;
  logic [KEY_MAX:0] len_hit;

  // new window with the current byte shifted in
  always_comb begin
    win_nxt[0] = din;
    for (int p = 1; p < WIN; p++) begin
      win_nxt[p] = win_r[p-1];
    end
  end

  // key length bounded, then cut at the first zero character
  always_comb begin
    len_cap = (key_len > 5'(KEY_MAX)) ? LW'(KEY_MAX) : LW'(key_len);
    eff_len = len_cap;
    for (int k = KEY_MAX - 1; k >= 0; k--) begin
      if ((LW'(k) < len_cap) && (key_chars[8*k +: 8] == CH_NUL)) begin
        eff_len = LW'(k);
      end
    end
  end

  // one compare per possible key length
  always_comb begin
    for (int l = 0; l <= KEY_MAX; l++) begin
      len_hit[l] = (win_nxt[0] == CH_DQUOTE) && (win_nxt[l+1] == CH_DQUOTE);
      for (int k = 0; k < KEY_MAX; k++) begin
        if (k < l) begin
          len_hit[l] = len_hit[l] && (win_nxt[l-k] == key_chars[8*k +: 8]);
        end
      end
    end
  end

  assign hit = len_hit[eff_len];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int p = 0; p < WIN; p++) begin
        win_r[p] <= 8'h00;
      end
    end else if (ctl.shift) begin
      win_r <= win_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/json_key_value_extractor_unit.sv =====
// json_key_value_extractor_unit: top level of the json key/value extractor
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/stall   | kvx_in_t  (doc_byte, doc_end)
//  out     | output    | out_valid/stall  | kvx_out_t (value char or summary)
//  cfg     | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// one byte per cycle while the result is not stalled; a request goes from the input
// register through the processing logic into the result register
// the window compare and the digit accumulate share the single logic level
// reset clears the key registers, the byte window and all scan state
// a stalled result holds the processing stage; the input register then holds
`default_nettype none

module json_key_value_extractor_unit
  import kvx_pkg::*;
#(
  parameter int KEY_MAX = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire kvx_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output kvx_out_t                  out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  logic [4:0]  key_len_r;
  logic [63:0] key_lo_r;
  logic [63:0] key_hi_r;

  logic    in_valid_r;
  kvx_in_t in_data_r;
  logic    adv;

  kvx_phase_t phase_r, phase_nxt;
  kvx_digit_t dstage_r, dstage_nxt;
  logic        quoted_r, quoted_nxt;
  logic        found_r, found_nxt;
  logic        openq_r, openq_nxt;
  logic        numok_r, numok_nxt;
  logic [15:0] len_r, len_nxt;
  logic [62:0] acc_r, acc_nxt;

  logic        out_valid_r;
  kvx_out_t    out_data_r;
  logic        res_valid;
  kvx_out_t    res_data;

  logic [7:0]  b;
  logic        is_end, is_sp, is_q, is_term, is_dig;
  logic        in_val, val_stop, emit, track;
  logic [3:0]  dig_val;
  logic [66:0] acc_x10, acc_sum;
  logic        hit;
  kvx_win_ctl_t win_ctl;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= '0;
      key_lo_r  <= '0;
      key_hi_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_LENGTH: key_len_r <= cfg_data[4:0];
        CFG_KEY_LOW:    key_lo_r  <= cfg_data;
        CFG_KEY_HIGH:   key_hi_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // byte decode
  assign b        = in_data_r.doc_byte;
  assign is_end   = in_data_r.doc_end || (b == CH_NUL);
  assign is_sp    = (b inside {CH_SPACE, [CH_TAB:CH_CR]});
  assign is_q     = (b inside {CH_DQUOTE, CH_SQUOTE});
  assign is_term  = is_sp || (b inside {CH_COMMA, CH_RBRACE, CH_RBRACKET});
  assign is_dig   = (b inside {[CH_ZERO:CH_NINE]});
  assign dig_val  = 4'(b - CH_ZERO);

  assign in_val   = ((phase_r == PH_SPACE) && !is_sp && !is_q) ||
                    (phase_r == PH_OPENED) || (phase_r == PH_VALUE);
  assign val_stop = quoted_r ? is_q : is_term;
  assign emit     = in_val && !val_stop;
  assign track    = in_val && !(quoted_r && is_q);

  assign acc_x10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
  assign acc_sum = acc_x10 + 67'(dig_val);

  // key window
  assign win_ctl.shift = adv && !is_end && (phase_r == PH_SEARCH);
  assign win_ctl.clear = adv && is_end;

  kvx_key_match #(
    .KEY_MAX (KEY_MAX)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (win_ctl),
    .din       (b),
    .key_len   (key_len_r),
    .key_chars ({key_hi_r, key_lo_r}),
    .hit       (hit)
  );

  // scan phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_end) begin
      phase_nxt = PH_SEARCH;
    end else if (in_val) begin
      phase_nxt = val_stop ? PH_DONE : PH_VALUE;
    end else begin
      case (phase_r)
        PH_SEARCH: if (hit) phase_nxt = PH_COLON;
        PH_COLON:  if (b == CH_COLON) phase_nxt = PH_SPACE;
        PH_SPACE:  if (is_q) phase_nxt = PH_OPENED;
        default:   phase_nxt = phase_r;
      endcase
    end
  end

  // value flags, length and number
  always_comb begin
    quoted_nxt = quoted_r;
    found_nxt  = found_r;
    openq_nxt  = openq_r;
    len_nxt    = len_r;
    dstage_nxt = dstage_r;
    numok_nxt  = numok_r;
    acc_nxt    = acc_r;
    if (is_end) begin
      quoted_nxt = 1'b0;
      found_nxt  = 1'b0;
      openq_nxt  = 1'b0;
      len_nxt    = '0;
      dstage_nxt = DS_START;
      numok_nxt  = 1'b0;
      acc_nxt    = '0;
    end else begin
      if ((phase_r == PH_SPACE) && !is_sp && is_q) begin
        quoted_nxt = 1'b1;
      end
      if (in_val) begin
        found_nxt = 1'b1;
        if (quoted_r && is_q) begin
          openq_nxt = 1'b0;
        end else if (phase_r == PH_OPENED) begin
          openq_nxt = 1'b1;
        end
      end
      if (emit && (len_r != LEN_MAX)) begin
        len_nxt = len_r + 16'd1;
      end
      if (track) begin
        case (dstage_r)
          DS_START: begin
            if (is_dig) begin
              numok_nxt  = 1'b1;
              acc_nxt    = 63'(dig_val);
              dstage_nxt = DS_DIGITS;
            end else begin
              dstage_nxt = DS_STOP;
            end
          end
          DS_DIGITS: begin
            if (is_dig) begin
              acc_nxt = (acc_sum > {4'b0000, NUM_MAX}) ? NUM_MAX : acc_sum[62:0];
            end else begin
              dstage_nxt = DS_STOP;
            end
          end
          default: dstage_nxt = dstage_r;
        endcase
      end
    end
  end

  // result
  always_comb begin
    res_valid = is_end || emit;
    res_data  = '0;
    if (is_end) begin
      res_data.is_summary   = 1'b1;
      res_data.found        = found_r;
      res_data.unterminated = openq_r;
      res_data.value_length = len_r;
      res_data.number_valid = numok_r;
      res_data.number       = numok_r ? acc_r : NUM_MAX;
    end else begin
      res_data.value_char = b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      dstage_r <= DS_START;
      quoted_r <= 1'b0;
      found_r  <= 1'b0;
      openq_r  <= 1'b0;
      numok_r  <= 1'b0;
      len_r    <= '0;
      acc_r    <= '0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      dstage_r <= dstage_nxt;
      quoted_r <= quoted_nxt;
      found_r  <= found_nxt;
      openq_r  <= openq_nxt;
      numok_r  <= numok_nxt;
      len_r    <= len_nxt;
      acc_r    <= acc_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
